@@ sv/sv39ptw_pkg.sv @@
// sv39ptw_pkg: types, codes and constants shared by the Sv39 page table walker
// used by sv39ptw_decide, sv39ptw_res_queue and sv39_page_table_walker_unit
package sv39ptw_pkg;

	localparam int LEVELS       = 3;
	localparam int PAGE_SHIFT   = 12;
	localparam int VPN_BITS     = 9;
	localparam int PPN_BITS     = 44;
	localparam int PADDR_BITS   = 56;
	localparam int XLEN         = 64;
	localparam int RES_DEPTH    = 4;
	localparam int IN_TDATA_W   = 136;
	localparam int OUT_TDATA_W  = 248;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 44;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROOT_PPN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRIV_MODE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MPRV      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PREV_MODE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SUM       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MXR       = 3'd5;

	// input selector
	localparam logic FUNC_REQUEST  = 1'b0;
	localparam logic FUNC_RESPONSE = 1'b1;

	// access types
	localparam logic [1:0] ACC_FETCH = 2'd0;
	localparam logic [1:0] ACC_LOAD  = 2'd1;
	localparam logic [1:0] ACC_STORE = 2'd2;
	localparam logic [1:0] ACC_RSVD  = 2'd3;

	// privilege modes
	localparam logic [1:0] MODE_USER    = 2'd0;
	localparam logic [1:0] MODE_SUPER   = 2'd1;
	localparam logic [1:0] MODE_MACHINE = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	// fault codes
	localparam logic [1:0] FAULT_NONE  = 2'd0;
	localparam logic [1:0] FAULT_INSTR = 2'd1;
	localparam logic [1:0] FAULT_LOAD  = 2'd2;
	localparam logic [1:0] FAULT_STORE = 2'd3;

	// pte bit positions
	localparam int PTE_V = 0;
	localparam int PTE_R = 1;
	localparam int PTE_W = 2;
	localparam int PTE_X = 3;
	localparam int PTE_U = 4;
	localparam int PTE_A = 6;
	localparam int PTE_D = 7;
	localparam int PTE_PPN_LSB = 10;

	localparam logic [1:0] TOP_LEVEL = 2'(LEVELS - 1);

	typedef struct packed {
		logic [PPN_BITS-1:0] root_ppn;
		logic [1:0]          priv_mode;
		logic                mprv;
		logic [1:0]          prev_mode;
		logic                sum;
		logic                mxr;
	} cfg_t;

	typedef struct packed {
		logic                  busy;
		logic [1:0]            level;
		logic [XLEN-1:0]       held_vaddr;
		logic [1:0]            held_type;
		logic                  held_amo;
		logic                  held_ef;
		logic [PADDR_BITS-1:0] pte_addr;
	} walk_state_t;

	typedef struct packed {
		logic            func;
		logic [XLEN-1:0] vaddr;
		logic [1:0]      access_type;
		logic            is_amo;
		logic            earlier_fault;
		logic [XLEN-1:0] pte_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0]            kind;
		logic [PADDR_BITS-1:0] mem_addr;
		logic [XLEN-1:0]       mem_wdata;
		logic [PADDR_BITS-1:0] page_base;
		logic [1:0]            fault_code;
		logic                  tval_to_machine;
		logic [XLEN-1:0]       fault_addr;
		logic                  last;
	} result_t;

endpackage

@@ sv/sv39ptw_decide.sv @@
// sv39ptw_decide: combinational decision for one registered input word
// depends on sv39ptw_pkg; gives the next walk state and up to two results
module sv39ptw_decide (
	input  sv39ptw_pkg::cfg_t        cfg,
	input  sv39ptw_pkg::walk_state_t st,
	input  sv39ptw_pkg::in_item_t    item,
	output sv39ptw_pkg::walk_state_t st_next,
	output logic [1:0]               res_n,
	output sv39ptw_pkg::result_t     res0,
	output sv39ptw_pkg::result_t     res1
);
	import sv39ptw_pkg::*;

	logic [XLEN-1:0]       pte;
	logic                  ifetch;
	logic                  store_acc;
	logic [1:0]            mode;
	logic                  perm_ok;
	logic                  allow;
	logic                  leaf_fault;
	logic [1:0]            fail_code;
	logic                  misalign;
	logic [PADDR_BITS-1:0] leaf_base;
	logic [VPN_BITS-1:0]   vpn_next;
	logic                  need_wb;
	logic                  is_pointer;
	result_t               fault_res;

	assign pte       = item.pte_data;
	assign ifetch    = (st.held_type == ACC_FETCH);
	assign store_acc = (st.held_type == ACC_STORE);
	assign mode      = (cfg.mprv && !ifetch) ? cfg.prev_mode : cfg.priv_mode;

	assign perm_ok = pte[PTE_V]
		&& !(mode == MODE_USER && !pte[PTE_U])
		&& !(pte[PTE_U] && mode == MODE_SUPER && (!cfg.sum || ifetch));

	assign allow = ifetch ? pte[PTE_X]
		: (st.held_type == ACC_LOAD) ? (pte[PTE_R] || (cfg.mxr && pte[PTE_X]))
		: pte[PTE_W];
	assign leaf_fault = !(perm_ok && allow);

	// amo load faults report as store faults
	assign fail_code = ifetch ? FAULT_INSTR
		: (st.held_type == ACC_LOAD) ? (st.held_amo ? FAULT_STORE : FAULT_LOAD)
		: FAULT_STORE;

	assign is_pointer = !pte[PTE_R] && !pte[PTE_X];

	always_comb begin
		unique case (st.level)
			2'd2: begin
				misalign  = |pte[27:PTE_PPN_LSB];
				leaf_base = {pte[53:28], st.held_vaddr[29:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
				vpn_next  = st.held_vaddr[29:21];
			end
			2'd1: begin
				misalign  = |pte[18:PTE_PPN_LSB];
				leaf_base = {pte[53:19], st.held_vaddr[20:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
				vpn_next  = st.held_vaddr[20:PAGE_SHIFT];
			end
			default: begin
				misalign  = 1'b0;
				leaf_base = {pte[53:PTE_PPN_LSB], {PAGE_SHIFT{1'b0}}};
				vpn_next  = st.held_vaddr[20:PAGE_SHIFT];
			end
		endcase
	end

	assign need_wb = !st.held_ef && (!pte[PTE_A] || (!pte[PTE_D] && store_acc));

	always_comb begin
		fault_res                 = '0;
		fault_res.kind            = KIND_DONE;
		fault_res.fault_code      = fail_code;
		fault_res.tval_to_machine = (cfg.priv_mode == MODE_MACHINE);
		fault_res.fault_addr      = st.held_vaddr;
		fault_res.last            = 1'b1;
	end

	always_comb begin
		st_next = st;
		res_n   = 2'd0;
		res0    = '0;
		res1    = '0;
		if (item.func == FUNC_REQUEST) begin
			st_next.held_vaddr = item.vaddr;
			st_next.held_type  = (item.access_type == ACC_RSVD) ? ACC_STORE : item.access_type;
			st_next.held_amo   = item.is_amo;
			st_next.held_ef    = item.earlier_fault;
			st_next.level      = TOP_LEVEL;
			st_next.busy       = 1'b1;
			st_next.pte_addr   = {cfg.root_ppn, item.vaddr[38:30], 3'b000};
			res_n              = 2'd1;
			res0.kind          = KIND_READ;
			res0.mem_addr      = {cfg.root_ppn, item.vaddr[38:30], 3'b000};
			res0.last          = 1'b1;
		end else if (st.busy) begin
			res_n = 2'd1;
			if (!pte[PTE_V]) begin
				st_next.busy = 1'b0;
				res0         = fault_res;
			end else if (is_pointer) begin
				if (st.level == 2'd0) begin
					st_next.busy = 1'b0;
					res0         = fault_res;
				end else begin
					st_next.level    = st.level - 2'd1;
					st_next.pte_addr = {pte[53:PTE_PPN_LSB], vpn_next, 3'b000};
					res0.kind        = KIND_READ;
					res0.mem_addr    = {pte[53:PTE_PPN_LSB], vpn_next, 3'b000};
					res0.last        = 1'b1;
				end
			end else if (leaf_fault || misalign) begin
				st_next.busy = 1'b0;
				res0         = fault_res;
			end else begin
				st_next.busy = 1'b0;
				if (need_wb) begin
					res_n          = 2'd2;
					res0.kind      = KIND_WRITE;
					res0.mem_addr  = st.pte_addr;
					res0.mem_wdata = pte | 64'h40 | (store_acc ? 64'h80 : 64'h0);
					res1.kind      = KIND_DONE;
					res1.page_base = leaf_base;
					res1.last      = 1'b1;
				end else begin
					res0.kind      = KIND_DONE;
					res0.page_base = st.held_ef ? '0 : leaf_base;
					res0.last      = 1'b1;
				end
			end
		end
	end

endmodule

@@ sv/sv39ptw_res_queue.sv @@
// sv39ptw_res_queue: small result queue, takes up to two results a cycle
// depends on sv39ptw_pkg for the result type
module sv39ptw_res_queue #(
	parameter int DEPTH = sv39ptw_pkg::RES_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           push_n,
	input  sv39ptw_pkg::result_t push0,
	input  sv39ptw_pkg::result_t push1,
	output logic                 room,
	output logic                 head_valid,
	output sv39ptw_pkg::result_t head,
	input  logic                 pop
);
	import sv39ptw_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	result_t          mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] wr_ptr_1;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_ptr_1   = ptr_inc(wr_ptr_q);
	assign room       = (count_q <= CNT_W'(DEPTH - 2));
	assign head_valid = (count_q != '0);
	assign head       = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem[wr_ptr_q] <= push0;
		if (push_n == 2'd2)
			mem[wr_ptr_1] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_n == 2'd1)
				wr_ptr_q <= wr_ptr_1;
			else if (push_n == 2'd2)
				wr_ptr_q <= ptr_inc(wr_ptr_1);
			if (pop && head_valid)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			count_q <= count_q + CNT_W'(push_n) - CNT_W'(pop && head_valid);
		end
	end

endmodule

@@ sv/sv39_page_table_walker_unit.sv @@
// sv39_page_table_walker_unit: top level of the Sv39 page table walker
// depends on sv39ptw_pkg, sv39ptw_decide and sv39ptw_res_queue
//
// A request word or a pte response word is taken into an input register; from
// there it is decided against the walk state and its one or two results go into
// a result queue, so a word can be accepted in every cycle while the queue has
// room, and the first result of a word reaches the master side through the input
// register and the result queue. The input register only moves on while the
// result queue has room for two results; with the master side always ready the
// input stalls only when walks that end in a pte write-back follow each other
// closely, since each such final step puts two results into the queue. Memory
// latency between a read request and its response sets the pace of a walk: one
// response word per level, three levels at most.
module sv39_page_table_walker_unit #(
	parameter int RES_DEPTH = sv39ptw_pkg::RES_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [sv39ptw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sv39ptw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// vaddr, access_type, is_amo, earlier_fault, pte_data, zero pad
	input  logic [sv39ptw_pkg::IN_TDATA_W-1:0]   s_tdata,
	// func
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// mem_addr, mem_wdata, page_base, fault_code, tval_to_machine, fault_addr, zero pad
	output logic [sv39ptw_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// kind
	output logic [1:0]                           m_tuser,
	output logic                                 m_tlast
);
	import sv39ptw_pkg::*;

	cfg_t        cfg_q;
	walk_state_t state_q;
	walk_state_t state_next;
	logic        in_valid_s1;
	in_item_t    in_item_s1;
	logic        fire;
	logic        room;
	logic [1:0]  res_n;
	result_t     res0;
	result_t     res1;
	result_t     head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.root_ppn  <= '0;
			cfg_q.priv_mode <= MODE_MACHINE;
			cfg_q.mprv      <= 1'b0;
			cfg_q.prev_mode <= MODE_USER;
			cfg_q.sum       <= 1'b0;
			cfg_q.mxr       <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROOT_PPN:  cfg_q.root_ppn  <= cfg_wdata[PPN_BITS-1:0];
				REG_PRIV_MODE: cfg_q.priv_mode <= cfg_wdata[1:0];
				REG_MPRV:      cfg_q.mprv      <= cfg_wdata[0];
				REG_PREV_MODE: cfg_q.prev_mode <= cfg_wdata[1:0];
				REG_SUM:       cfg_q.sum       <= cfg_wdata[0];
				REG_MXR:       cfg_q.mxr       <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign fire     = in_valid_s1 && room;
	assign s_tready = !in_valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_item_s1.func          <= s_tuser;
			in_item_s1.vaddr         <= s_tdata[63:0];
			in_item_s1.access_type   <= s_tdata[65:64];
			in_item_s1.is_amo        <= s_tdata[66];
			in_item_s1.earlier_fault <= s_tdata[67];
			in_item_s1.pte_data      <= s_tdata[131:68];
		end
	end

	sv39ptw_decide u_decide (
		.cfg     (cfg_q),
		.st      (state_q),
		.item    (in_item_s1),
		.st_next (state_next),
		.res_n   (res_n),
		.res0    (res0),
		.res1    (res1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.busy       <= 1'b0;
			state_q.level      <= TOP_LEVEL;
			state_q.held_vaddr <= '0;
			state_q.held_type  <= ACC_FETCH;
			state_q.held_amo   <= 1'b0;
			state_q.held_ef    <= 1'b0;
			state_q.pte_addr   <= '0;
		end else if (fire) begin
			state_q <= state_next;
		end
	end

	sv39ptw_res_queue #(
		.DEPTH (RES_DEPTH)
	) u_res_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (fire ? res_n : 2'd0),
		.push0      (res0),
		.push1      (res1),
		.room       (room),
		.head_valid (m_tvalid),
		.head       (head),
		.pop        (m_tready)
	);

	assign m_tuser = head.kind;
	assign m_tlast = head.last;
	assign m_tdata = {5'b0, head.fault_addr, head.tval_to_machine, head.fault_code,
		head.page_base, head.mem_wdata, head.mem_addr};

endmodule
